### src/kts_pkg.sv
// shared types, codes and helpers of the keyframe track sampler
package kts_pkg;

	localparam int TIME_W      = 16;
	localparam int DATA_W      = 32;
	localparam int U_W         = 16;
	localparam int IN_TDATA_W  = 232;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 104;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int MUL_W       = 33;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W + 2;

	// item kinds carried on tuser
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// multiplier operand selections
	localparam logic [1:0] MOP_U2   = 2'd0;
	localparam logic [1:0] MOP_U3   = 2'd1;
	localparam logic [1:0] MOP_LIN  = 2'd2;
	localparam logic [1:0] MOP_HERM = 2'd3;

	// register index bit of paddr
	localparam logic REG_WRAP_PERIOD = 1'b0;
	localparam logic [TIME_W-1:0] WRAP_PERIOD_RST = 16'hFFFF;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] pos;
		logic [2:0][DATA_W-1:0] tan;
		logic                   spline;
	} kts_key_t;

	typedef struct packed {
		logic       capture;
		logic       exec_clear;
		logic       exec_load;
		logic       mod_start;
		logic       lat_t;
		logic       scan_clr;
		logic       scan_next;
		logic       kaddr_prev;
		logic       lat_k0;
		logic       lat_k1;
		logic       blend_start;
		logic       lat_u;
		logic       mul_en;
		logic [1:0] mop;
		logic       lat_u2;
		logic       lat_h;
		logic       acc_en;
		logic       term_clr;
		logic       term_inc;
		logic       axis_clr;
		logic       axis_inc;
		logic       res_lin;
		logic       res_herm;
		logic       res_hold;
		logic       out_load;
	} kts_cmd_t;

	typedef struct packed {
		logic       div_busy;
		logic       cnt_zero;
		logic       t_gt;
		logic       t_hold;
		logic       first;
		logic       spline_both;
		logic       term_last;
		logic       axis_last;
		logic [1:0] act;
	} kts_sts_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = 68'sd2147483647;
		lo = -68'sd2147483648;
		if (v > hi) begin
			return 32'h7FFFFFFF;
		end else if (v < lo) begin
			return 32'h80000000;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

### src/kts_ctrl.sv
// sequencer for clear, load and query items
module kts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_tvalid,
	output logic             in_tready,
	output logic             out_tvalid,
	input  logic             out_tready,
	input  kts_pkg::kts_sts_t sts,
	output kts_pkg::kts_cmd_t cmd
);
	import kts_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_EXEC = 5'd1;
	localparam logic [4:0] S_MOD  = 5'd2;
	localparam logic [4:0] S_SRD  = 5'd3;
	localparam logic [4:0] S_SCHK = 5'd4;
	localparam logic [4:0] S_HRD  = 5'd5;
	localparam logic [4:0] S_HLD  = 5'd6;
	localparam logic [4:0] S_RDA  = 5'd7;
	localparam logic [4:0] S_RDB  = 5'd8;
	localparam logic [4:0] S_LATB = 5'd9;
	localparam logic [4:0] S_DIV  = 5'd10;
	localparam logic [4:0] S_LMUL = 5'd11;
	localparam logic [4:0] S_LACC = 5'd12;
	localparam logic [4:0] S_U2   = 5'd13;
	localparam logic [4:0] S_U3   = 5'd14;
	localparam logic [4:0] S_H    = 5'd15;
	localparam logic [4:0] S_HMUL = 5'd16;
	localparam logic [4:0] S_HACC = 5'd17;
	localparam logic [4:0] S_HFIN = 5'd18;
	localparam logic [4:0] S_OUT  = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_nxt;
	logic       otv_q;
	logic       out_free;

	assign in_tready  = (state_q == S_IDLE);
	assign out_tvalid = otv_q;
	assign out_free   = !otv_q || out_tready;

	always_comb begin
		cmd       = '0;
		cmd.mop   = MOP_LIN;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.act)
					ACT_CLEAR: begin
						cmd.exec_clear = 1'b1;
						state_nxt      = S_OUT;
					end
					ACT_LOAD: begin
						cmd.exec_load = 1'b1;
						state_nxt     = S_OUT;
					end
					ACT_QUERY: begin
						cmd.mod_start = 1'b1;
						state_nxt     = S_MOD;
					end
					default: state_nxt = S_OUT;
				endcase
			end
			S_MOD: begin
				if (!sts.div_busy) begin
					cmd.lat_t    = 1'b1;
					cmd.scan_clr = 1'b1;
					state_nxt    = sts.cnt_zero ? S_OUT : S_SRD;
				end
			end
			S_SRD: state_nxt = S_SCHK;
			S_SCHK: begin
				if (sts.t_gt) begin
					state_nxt = sts.first ? S_OUT : S_RDA;
				end else if (sts.t_hold) begin
					state_nxt = S_HRD;
				end else begin
					cmd.scan_next = 1'b1;
					state_nxt     = S_SRD;
				end
			end
			S_HRD: state_nxt = S_HLD;
			S_HLD: begin
				cmd.res_hold = 1'b1;
				state_nxt    = S_OUT;
			end
			S_RDA: begin
				cmd.kaddr_prev = 1'b1;
				state_nxt      = S_RDB;
			end
			S_RDB: begin
				cmd.lat_k0      = 1'b1;
				cmd.blend_start = 1'b1;
				state_nxt       = S_LATB;
			end
			S_LATB: begin
				cmd.lat_k1 = 1'b1;
				state_nxt  = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					cmd.lat_u    = 1'b1;
					cmd.axis_clr = 1'b1;
					cmd.term_clr = 1'b1;
					state_nxt    = sts.spline_both ? S_U2 : S_LMUL;
				end
			end
			S_LMUL: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_LIN;
				state_nxt  = S_LACC;
			end
			S_LACC: begin
				cmd.res_lin = 1'b1;
				if (sts.axis_last) begin
					state_nxt = S_OUT;
				end else begin
					cmd.axis_inc = 1'b1;
					state_nxt    = S_LMUL;
				end
			end
			S_U2: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_U2;
				state_nxt  = S_U3;
			end
			S_U3: begin
				cmd.lat_u2 = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_U3;
				state_nxt  = S_H;
			end
			S_H: begin
				cmd.lat_h = 1'b1;
				state_nxt = S_HMUL;
			end
			S_HMUL: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_HERM;
				state_nxt  = S_HACC;
			end
			S_HACC: begin
				cmd.acc_en = 1'b1;
				if (sts.term_last) begin
					state_nxt = S_HFIN;
				end else begin
					cmd.term_inc = 1'b1;
					state_nxt    = S_HMUL;
				end
			end
			S_HFIN: begin
				cmd.res_herm = 1'b1;
				cmd.term_clr = 1'b1;
				if (sts.axis_last) begin
					state_nxt = S_OUT;
				end else begin
					cmd.axis_inc = 1'b1;
					state_nxt    = S_HMUL;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			otv_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				otv_q <= 1'b1;
			end else if (out_tready) begin
				otv_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!otv_q || out_tready))
		else $error("result loaded over an untaken beat");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_tvalid && in_tready) |=> (state_q == S_EXEC))
		else $error("accepted beat not executed");

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mod_start || cmd.blend_start) |=> sts.div_busy)
		else $error("divider did not start");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE))
		else $error("result load outside item end");

endmodule

### src/kts_dp.sv
// key tables, divider, multiplier and result registers
module kts_dp #(
	parameter int MAX_KEYS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kts_pkg::kts_cmd_t                  cmd,
	output kts_pkg::kts_sts_t                  sts,
	input  logic [kts_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  logic [kts_pkg::IN_TUSER_W-1:0]     in_tuser,
	input  logic [kts_pkg::TIME_W-1:0]         wrap_period,
	output logic [kts_pkg::OUT_TDATA_W-1:0]    out_tdata
);
	import kts_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam logic signed [51:0] ONE_Q48 = 52'sh1000000000000;

	// key tables
	logic [TIME_W-1:0] times_mem [MAX_KEYS];
	kts_key_t          keys_mem  [MAX_KEYS];

	logic [1:0]        act_q;
	logic [TIME_W-1:0] ktime_q;
	logic [TIME_W-1:0] qtime_q;
	kts_key_t          kin_q;
	logic [CW-1:0]     cnt_q;
	logic              tbl_full;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     kaddr;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] t0_q;
	logic [TIME_W-1:0] rd_time_q;
	kts_key_t          kd_q;
	kts_key_t          k0_q;
	kts_key_t          k1_q;

	logic [16:0]          div_rem_q;
	logic [31:0]          div_quo_q;
	logic [TIME_W-1:0]    div_den_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_busy_q;
	logic [16:0]          div_r;
	logic                 div_ge;

	logic [U_W-1:0]             u_q;
	logic [31:0]                u2_q;
	logic [3:0][DATA_W-1:0]     h_q;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_ext;
	logic [1:0]                 term_q;
	logic [1:0]                 axis_q;
	logic [DATA_W-1:0]          sel_op;
	logic [DATA_W-1:0]          p0_ax;
	logic [DATA_W-1:0]          p1_ax;

	logic signed [51:0] u3e, u2e, ue;
	logic signed [51:0] h0, h1, h2, h3;
	logic signed [51:0] hs0, hs1, hs2, hs3;
	logic signed [PROD_W-1:0] lin_sh;
	logic signed [ACC_W-1:0]  lin_sum;
	logic signed [ACC_W-1:0]  herm_sh;

	logic [2:0][DATA_W-1:0] res_pos_q;
	logic                   res_valid_q;
	logic                   res_full_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	assign tbl_full = (cnt_q >= CW'(MAX_KEYS));
	assign kaddr    = cmd.kaddr_prev ? (i_q - AW'(1)) : i_q;

	// capture of the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q          <= in_tuser;
			ktime_q        <= in_tdata[15:0];
			kin_q.pos[0]   <= in_tdata[47:16];
			kin_q.pos[1]   <= in_tdata[79:48];
			kin_q.pos[2]   <= in_tdata[111:80];
			kin_q.tan[0]   <= in_tdata[143:112];
			kin_q.tan[1]   <= in_tdata[175:144];
			kin_q.tan[2]   <= in_tdata[207:176];
			kin_q.spline   <= in_tdata[208];
			qtime_q        <= in_tdata[224:209];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_load && !tbl_full) begin
			times_mem[cnt_q[AW-1:0]] <= ktime_q;
			keys_mem[cnt_q[AW-1:0]]  <= kin_q;
		end
		rd_time_q <= times_mem[i_q];
		kd_q      <= keys_mem[kaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec_clear) begin
			cnt_q <= '0;
		end else if (cmd.exec_load && !tbl_full) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// scan pointer and previous key time
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			i_q <= '0;
		end else if (cmd.scan_next) begin
			i_q  <= i_q + AW'(1);
			t0_q <= rd_time_q;
		end
		if (cmd.lat_t) begin
			t_q <= (wrap_period == '0) ? qtime_q : div_rem_q[TIME_W-1:0];
		end
		if (cmd.lat_k0) begin
			k0_q <= kd_q;
		end
		if (cmd.lat_k1) begin
			k1_q <= kd_q;
		end
	end

	// shared restoring divider, one quotient bit a cycle
	assign div_r  = {div_rem_q[15:0], div_quo_q[31]};
	assign div_ge = (div_r >= {1'b0, div_den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.mod_start || cmd.blend_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			div_quo_q <= {16'b0, qtime_q};
			div_den_q <= wrap_period;
			div_rem_q <= '0;
		end else if (cmd.blend_start) begin
			div_quo_q <= {t_q - t0_q, 16'b0};
			div_den_q <= rd_time_q - t0_q;
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			div_quo_q <= {div_quo_q[30:0], div_ge};
			div_rem_q <= div_ge ? (div_r - {1'b0, div_den_q}) : div_r;
		end
	end

	// multiplier operands
	assign p0_ax = k0_q.pos[axis_q];
	assign p1_ax = k1_q.pos[axis_q];

	always_comb begin
		case (term_q)
			2'd0:    sel_op = k0_q.pos[axis_q];
			2'd1:    sel_op = k0_q.tan[axis_q];
			2'd2:    sel_op = k1_q.pos[axis_q];
			default: sel_op = k1_q.tan[axis_q];
		endcase
		case (cmd.mop)
			MOP_U2: begin
				mul_a = {17'b0, u_q};
				mul_b = {17'b0, u_q};
			end
			MOP_U3: begin
				// u squared is still in the product register here
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {17'b0, u_q};
			end
			MOP_LIN: begin
				mul_a = {p1_ax[31], p1_ax} - {p0_ax[31], p0_ax};
				mul_b = {17'b0, u_q};
			end
			MOP_HERM: begin
				mul_a = {sel_op[31], sel_op};
				mul_b = {h_q[term_q][31], h_q[term_q]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// hermite basis in Q48, floored to Q30
	assign u3e = {4'b0, prod_q[47:0]};
	assign u2e = {4'b0, u2_q, 16'b0};
	assign ue  = {4'b0, u_q, 32'b0};
	assign h0  = (u3e <<< 1) - ((u2e <<< 1) + u2e) + ONE_Q48;
	assign h1  = u3e - (u2e <<< 1) + ue;
	assign h2  = ((u2e <<< 1) + u2e) - (u3e <<< 1);
	assign h3  = u3e - u2e;
	assign hs0 = h0 >>> 18;
	assign hs1 = h1 >>> 18;
	assign hs2 = h2 >>> 18;
	assign hs3 = h3 >>> 18;

	assign prod_ext = {{2{prod_q[PROD_W-1]}}, prod_q};
	assign lin_sh   = prod_q >>> 16;
	assign lin_sum  = {{(ACC_W-DATA_W){p0_ax[31]}}, p0_ax}
		+ {{(ACC_W-PROD_W){lin_sh[PROD_W-1]}}, lin_sh};
	assign herm_sh  = acc_q >>> 30;

	always_ff @(posedge clk) begin
		if (cmd.lat_u) begin
			u_q <= div_quo_q[U_W-1:0];
		end
		if (cmd.lat_u2) begin
			u2_q <= prod_q[31:0];
		end
		if (cmd.lat_h) begin
			h_q[0] <= hs0[DATA_W-1:0];
			h_q[1] <= hs1[DATA_W-1:0];
			h_q[2] <= hs2[DATA_W-1:0];
			h_q[3] <= hs3[DATA_W-1:0];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_en) begin
			acc_q <= (term_q == 2'd0) ? prod_ext : (acc_q + prod_ext);
		end
		if (cmd.term_clr) begin
			term_q <= 2'd0;
		end else if (cmd.term_inc) begin
			term_q <= term_q + 2'd1;
		end
		if (cmd.axis_clr) begin
			axis_q <= 2'd0;
		end else if (cmd.axis_inc) begin
			axis_q <= axis_q + 2'd1;
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_pos_q   <= '0;
			res_valid_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else begin
			if (cmd.exec_load && tbl_full) begin
				res_full_q <= 1'b1;
			end
			if (cmd.res_lin) begin
				res_pos_q[axis_q] <= sat32(lin_sum);
				res_valid_q       <= 1'b1;
			end
			if (cmd.res_herm) begin
				res_pos_q[axis_q] <= sat32(herm_sh);
				res_valid_q       <= 1'b1;
			end
			if (cmd.res_hold) begin
				res_pos_q   <= kd_q.pos;
				res_valid_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			out_data_q <= {6'b0, res_full_q, res_valid_q,
				res_pos_q[2], res_pos_q[1], res_pos_q[0]};
		end
	end

	assign out_tdata = out_data_q;

	assign sts.div_busy    = div_busy_q;
	assign sts.cnt_zero    = (cnt_q == '0);
	assign sts.t_gt        = (rd_time_q > t_q);
	assign sts.t_hold      = (rd_time_q == t_q) || ((CW'(i_q) + CW'(1)) == cnt_q);
	assign sts.first       = (i_q == '0);
	assign sts.spline_both = k0_q.spline && k1_q.spline;
	assign sts.term_last   = (term_q == 2'd3);
	assign sts.axis_last   = (axis_q == 2'd2);
	assign sts.act         = act_q;

endmodule

### src/keyframe_track_sampler.sv
// top level: stream ports, configuration register and the two halves
//
// channel   direction  beat contents
// s_axis    in         clear, load key or query (kind on tuser)
// m_axis    out        one result per input beat
// apb       in/out     wrap period register at byte address 0
//
// clear and load run straight to the output; a query runs the 32-step shared divider once to
// wrap the query time and, when it blends between two keys, a second time for the blend
// fraction, and a hermite blend forms all its terms in turn on the one 33x33 multiplier.
// one item is in work at a time; the result sits in an output register so the next beat
// is taken while it waits.
// reset empties the key table and sets the wrap period to 65535.
module keyframe_track_sampler #(
	parameter int MAX_KEYS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// key_time, value_x, value_y, value_z, tangent_x, tangent_y, tangent_z,
	// spline_flag, query_time, 7 bits zero
	input  logic [kts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// action
	input  logic [kts_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_x, out_y, out_z, out_valid, table_full, 6 bits zero
	output logic [kts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kts_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [kts_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [kts_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import kts_pkg::*;

	logic [TIME_W-1:0] wrap_period_q;
	kts_cmd_t          cmd;
	kts_sts_t          sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_period_q <= WRAP_PERIOD_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WRAP_PERIOD)) begin
			wrap_period_q <= pwdata[TIME_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_WRAP_PERIOD) ? {16'b0, wrap_period_q} : '0;

	kts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	kts_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_tdata    (s_axis_tdata),
		.in_tuser    (s_axis_tuser),
		.wrap_period (wrap_period_q),
		.out_tdata   (m_axis_tdata)
	);

endmodule
